>>> rtl/lrd_pkg.sv
// shared types, constants and saturating add for the lens distortion block
package lrd_pkg;

    localparam int PIX_W     = 20;
    localparam int FOC_W     = 24;
    localparam int COEF_W    = 32;
    localparam int OUT_W     = 24;
    localparam int VAL_W     = 48;
    localparam int NORM_FRAC = 24;
    localparam int NUM_W     = PIX_W + NORM_FRAC;
    localparam int REM_W     = FOC_W;
    localparam int CFG_IDX_W = 3;

    // divider: offset stage, one stage per quotient bit, rounding stage
    localparam int DIV_LAT = NUM_W + 2;
    // multiplier: magnitude, partial products, sum, round, shift and sign
    localparam int MUL_LAT = 5;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = -VAL_MAX;
    localparam logic signed [VAL_W:0]   SUM_MAX = {2'b00, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W:0]   SUM_MIN = -SUM_MAX;

    typedef enum logic [1:0] {
        SH_24 = 2'd0,
        SH_28 = 2'd1,
        SH_29 = 2'd2
    } shift_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X    = 3'd0,
        REG_FOCAL_Y    = 3'd1,
        REG_CENTER_X   = 3'd2,
        REG_CENTER_Y   = 3'd3,
        REG_RADIAL_K1  = 3'd4,
        REG_RADIAL_K2  = 3'd5,
        REG_TANGENT_P1 = 3'd6,
        REG_TANGENT_P2 = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix_u;
        logic [PIX_W-1:0] pix_v;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] dist_u;
        logic signed [OUT_W-1:0] dist_v;
        logic                    bad_focal;
        logic                    clipped;
    } out_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    sat;
    } sval_t;

    function automatic sval_t sat_add(input logic signed [VAL_W-1:0] a,
                                      input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        sval_t r;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        if (s > SUM_MAX) begin
            r.val = VAL_MAX;
            r.sat = 1'b1;
        end else if (s < SUM_MIN) begin
            r.val = VAL_MIN;
            r.sat = 1'b1;
        end else begin
            r.val = s[VAL_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/lrd_mul.sv
// pipelined signed multiply with rounded right shift and saturation
module lrd_mul
    import lrd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  shift_t                  sh,
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [VAL_W-1:0] b,
    output logic signed [VAL_W-1:0] p,
    output logic                    sat
);

    localparam int HALF_W = VAL_W / 2;
    localparam int PROD_W = 2 * VAL_W;
    localparam int RND_W  = 64;

    logic [VAL_W-1:0]        ma_reg, mb_reg, ma_next, mb_next;
    logic                    neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [VAL_W-1:0]        pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [RND_W-1:0]        rnd_reg, rnd_next, half, shifted;
    logic                    ovf_reg, ovf_next, big;
    logic [VAL_W-1:0]        mag;
    logic signed [VAL_W-1:0] p_reg, p_next;
    logic                    sat_reg;

    always_comb begin
        ma_next = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
        mb_next = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);

        prod_next = PROD_W'(pp_ll_reg)
                  + (PROD_W'(pp_lh_reg) << HALF_W)
                  + (PROD_W'(pp_hl_reg) << HALF_W)
                  + (PROD_W'(pp_hh_reg) << VAL_W);

        case (sh)
            SH_28: begin
                half    = RND_W'(1) << 27;
                shifted = rnd_reg >> 28;
            end
            SH_29: begin
                half    = RND_W'(1) << 28;
                shifted = rnd_reg >> 29;
            end
            default: begin
                half    = RND_W'(1) << 23;
                shifted = rnd_reg >> 24;
            end
        endcase

        // a product at or above 2^63 saturates whatever the shift
        ovf_next = |prod_reg[PROD_W-1:RND_W-1];
        rnd_next = {1'b0, prod_reg[RND_W-2:0]} + half;

        big    = ovf_reg || (|shifted[RND_W-1:VAL_W-1]);
        mag    = big ? VAL_MAX : {1'b0, shifted[VAL_W-2:0]};
        p_next = neg4_reg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            neg1_reg  <= a[VAL_W-1] ^ b[VAL_W-1];
            pp_ll_reg <= ma_reg[HALF_W-1:0] * mb_reg[HALF_W-1:0];
            pp_lh_reg <= ma_reg[HALF_W-1:0] * mb_reg[VAL_W-1:HALF_W];
            pp_hl_reg <= ma_reg[VAL_W-1:HALF_W] * mb_reg[HALF_W-1:0];
            pp_hh_reg <= ma_reg[VAL_W-1:HALF_W] * mb_reg[VAL_W-1:HALF_W];
            neg2_reg  <= neg1_reg;
            prod_reg  <= prod_next;
            neg3_reg  <= neg2_reg;
            rnd_reg   <= rnd_next;
            ovf_reg   <= ovf_next;
            neg4_reg  <= neg3_reg;
            p_reg     <= p_next;
            sat_reg   <= big;
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;

endmodule

>>> rtl/lrd_div.sv
// pipelined restoring divider: rounded (p - c) / f in q.24, one quotient bit per stage
module lrd_div
    import lrd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic [PIX_W-1:0]        p,
    input  logic [PIX_W-1:0]        c,
    input  logic [FOC_W-1:0]        f,
    output logic signed [VAL_W-1:0] q
);

    logic [REM_W-1:0]        rem_reg  [0:NUM_W];
    logic [REM_W-1:0]        rem_next [0:NUM_W];
    logic [NUM_W-1:0]        num_reg  [0:NUM_W];
    logic [NUM_W-1:0]        num_next [0:NUM_W];
    logic                    neg_reg  [0:NUM_W];
    logic                    neg_next [0:NUM_W];
    logic [REM_W:0]          trial    [1:NUM_W];
    logic signed [PIX_W:0]   diff;
    logic [PIX_W-1:0]        dmag;
    logic                    bump;
    logic [VAL_W-1:0]        qmag;
    logic signed [VAL_W-1:0] q_reg, q_next;

    always_comb begin
        diff = $signed({1'b0, p}) - $signed({1'b0, c});
        dmag = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
        rem_next[0] = '0;
        num_next[0] = {dmag, {NORM_FRAC{1'b0}}};
        neg_next[0] = diff[PIX_W];

        // num holds the dividend bits still to come and shifts in quotient bits
        for (int k = 1; k <= NUM_W; k++) begin
            trial[k] = {rem_reg[k-1], num_reg[k-1][NUM_W-1]};
            if (trial[k] >= {1'b0, f}) begin
                rem_next[k] = REM_W'(trial[k] - {1'b0, f});
                num_next[k] = {num_reg[k-1][NUM_W-2:0], 1'b1};
            end else begin
                rem_next[k] = trial[k][REM_W-1:0];
                num_next[k] = {num_reg[k-1][NUM_W-2:0], 1'b0};
            end
            neg_next[k] = neg_reg[k-1];
        end

        // round half away from zero: bump when twice the remainder reaches f
        bump   = ({rem_reg[NUM_W], 1'b0} >= {1'b0, f});
        qmag   = VAL_W'(num_reg[NUM_W]) + VAL_W'(bump);
        q_next = neg_reg[NUM_W] ? -$signed(qmag) : $signed(qmag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= NUM_W; k++) begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
                neg_reg[k] <= neg_next[k];
            end
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/radial_tangential_lens_distort.sv
// top level: radial and tangential lens distortion of one pixel coordinate per item
//
//   port group   dir   carries
//   s_*          in    pixel item: pix_u, pix_v (q12.8)
//   m_*          out   result item: dist_u, dist_v (q15.8), bad_focal, clipped
//   cfg_*        in    register writes: focal, center, k1, k2, p1, p2
//
// one item per cycle unless the output stalls; an item reaches m_valid through
// the 46-stage divider, five chained 5-stage multipliers and five add stages
// every stage moves together; m_ready low with a held result freezes the pipe
// aresetn (synchronous) clears the valid bits and loads register defaults
module radial_tangential_lens_distort
    import lrd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]    cfg_wdata
);

    localparam int S_XY  = DIV_LAT;
    localparam int S_SQ  = S_XY + MUL_LAT;
    localparam int S_R2  = S_SQ + 1;
    localparam int S_T   = S_R2 + 1;
    localparam int S_R4  = S_R2 + MUL_LAT;
    localparam int S_K2  = S_R4 + MUL_LAT;
    localparam int S_RAD = S_K2 + 1;
    localparam int S_PR  = S_RAD + MUL_LAT;
    localparam int S_D1  = S_PR + 1;
    localparam int S_D   = S_D1 + 1;
    localparam int S_OFF = S_D + MUL_LAT;
    localparam int S_OUT = S_OFF + 1;

    localparam int XY_DLY = S_RAD - S_XY;
    localparam int PR_DLY = S_RAD - S_SQ;
    localparam int T_DLY  = S_RAD - S_T;
    localparam int K1_DLY = S_K2 - S_R4;

    localparam logic signed [VAL_W:0] OUT_HI = (VAL_W+1)'(2**(OUT_W-1) - 1);
    localparam logic signed [VAL_W:0] OUT_LO = (VAL_W+1)'(-(2**(OUT_W-1)));

    typedef struct packed {
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
        logic             sat;
    } side_t;

    // configuration
    logic [FOC_W-1:0]         focal_x_reg, focal_y_reg;
    logic [PIX_W-1:0]         center_x_reg, center_y_reg;
    logic signed [COEF_W-1:0] radial_k1_reg, radial_k2_reg;
    logic signed [COEF_W-1:0] tangent_p1_reg, tangent_p2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg    <= FOC_W'(256);
            focal_y_reg    <= FOC_W'(256);
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radial_k1_reg  <= '0;
            radial_k2_reg  <= '0;
            tangent_p1_reg <= '0;
            tangent_p2_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_FOCAL_X:    focal_x_reg    <= cfg_wdata[FOC_W-1:0];
                REG_FOCAL_Y:    focal_y_reg    <= cfg_wdata[FOC_W-1:0];
                REG_CENTER_X:   center_x_reg   <= cfg_wdata[PIX_W-1:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_wdata[PIX_W-1:0];
                REG_RADIAL_K1:  radial_k1_reg  <= cfg_wdata;
                REG_RADIAL_K2:  radial_k2_reg  <= cfg_wdata;
                REG_TANGENT_P1: tangent_p1_reg <= cfg_wdata;
                REG_TANGENT_P2: tangent_p2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [VAL_W-1:0] k1_ext, k2_ext, p1_ext, p2_ext, fx_ext, fy_ext;
    assign k1_ext = VAL_W'(radial_k1_reg);
    assign k2_ext = VAL_W'(radial_k2_reg);
    assign p1_ext = VAL_W'(tangent_p1_reg);
    assign p2_ext = VAL_W'(tangent_p2_reg);
    assign fx_ext = VAL_W'(focal_x_reg);
    assign fy_ext = VAL_W'(focal_y_reg);

    // pipeline control
    logic             adv;
    logic [S_OUT:0]   vld_reg;
    side_t            side_reg  [0:S_OFF];
    side_t            side_next [0:S_OFF];
    logic             sat_ev    [0:S_OFF];

    assign adv     = !vld_reg[S_OUT] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[S_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[S_OUT-1:0], s_valid};
        end
    end

    // normalize
    logic signed [VAL_W-1:0] x_q, y_q;

    lrd_div u_div_x (
        .aclk (aclk), .en (adv), .p (side_reg[0].u), .c (center_x_reg),
        .f (focal_x_reg), .q (x_q)
    );
    lrd_div u_div_y (
        .aclk (aclk), .en (adv), .p (side_reg[0].v), .c (center_y_reg),
        .f (focal_y_reg), .q (y_q)
    );

    // squares and cross term
    logic signed [VAL_W-1:0] xx_p, yy_p, xy_p;
    logic                    xx_sat, yy_sat, xy_sat;

    lrd_mul u_mul_xx (.aclk (aclk), .en (adv), .sh (SH_24), .a (x_q), .b (x_q),
                      .p (xx_p), .sat (xx_sat));
    lrd_mul u_mul_yy (.aclk (aclk), .en (adv), .sh (SH_24), .a (y_q), .b (y_q),
                      .p (yy_p), .sat (yy_sat));
    lrd_mul u_mul_xy (.aclk (aclk), .en (adv), .sh (SH_24), .a (x_q), .b (y_q),
                      .p (xy_p), .sat (xy_sat));

    sval_t                   r2_s, xx2_s, yy2_s, tx_s, ty_s;
    logic signed [VAL_W-1:0] r2_reg, xx2_reg, yy2_reg, tx_reg, ty_reg;

    assign r2_s  = sat_add(xx_p, yy_p);
    assign xx2_s = sat_add(xx_p, xx_p);
    assign yy2_s = sat_add(yy_p, yy_p);
    assign tx_s  = sat_add(r2_reg, xx2_reg);
    assign ty_s  = sat_add(r2_reg, yy2_reg);

    // radial polynomial
    logic signed [VAL_W-1:0] r4_p, k1r2_p, k2r4_p;
    logic                    r4_sat, k1r2_sat, k2r4_sat;

    lrd_mul u_mul_r4 (.aclk (aclk), .en (adv), .sh (SH_24), .a (r2_reg), .b (r2_reg),
                      .p (r4_p), .sat (r4_sat));
    lrd_mul u_mul_k1 (.aclk (aclk), .en (adv), .sh (SH_29), .a (k1_ext), .b (r2_reg),
                      .p (k1r2_p), .sat (k1r2_sat));
    lrd_mul u_mul_k2 (.aclk (aclk), .en (adv), .sh (SH_29), .a (k2_ext), .b (r4_p),
                      .p (k2r4_p), .sat (k2r4_sat));

    logic signed [VAL_W-1:0] k1_dly_reg [0:K1_DLY-1];
    logic signed [VAL_W-1:0] x_dly_reg  [0:XY_DLY-1];
    logic signed [VAL_W-1:0] y_dly_reg  [0:XY_DLY-1];
    logic signed [VAL_W-1:0] xy_dly_reg [0:PR_DLY-1];
    logic signed [VAL_W-1:0] tx_dly_reg [0:T_DLY-1];
    logic signed [VAL_W-1:0] ty_dly_reg [0:T_DLY-1];
    sval_t                   rad_s;
    logic signed [VAL_W-1:0] rad_reg;

    assign rad_s = sat_add(k1_dly_reg[K1_DLY-1], k2r4_p);

    // distortion terms
    logic signed [VAL_W-1:0] xr_p, yr_p, p1xy_p, p2xy_p, p2t_p, p1t_p;
    logic                    xr_sat, yr_sat, p1xy_sat, p2xy_sat, p2t_sat, p1t_sat;

    lrd_mul u_mul_xr (.aclk (aclk), .en (adv), .sh (SH_24),
                      .a (x_dly_reg[XY_DLY-1]), .b (rad_reg), .p (xr_p), .sat (xr_sat));
    lrd_mul u_mul_yr (.aclk (aclk), .en (adv), .sh (SH_24),
                      .a (y_dly_reg[XY_DLY-1]), .b (rad_reg), .p (yr_p), .sat (yr_sat));
    // the factor two of 2*p*xy folds into a shift one short
    lrd_mul u_mul_p1xy (.aclk (aclk), .en (adv), .sh (SH_28),
                        .a (p1_ext), .b (xy_dly_reg[PR_DLY-1]), .p (p1xy_p), .sat (p1xy_sat));
    lrd_mul u_mul_p2xy (.aclk (aclk), .en (adv), .sh (SH_28),
                        .a (p2_ext), .b (xy_dly_reg[PR_DLY-1]), .p (p2xy_p), .sat (p2xy_sat));
    lrd_mul u_mul_p2t (.aclk (aclk), .en (adv), .sh (SH_29),
                       .a (p2_ext), .b (tx_dly_reg[T_DLY-1]), .p (p2t_p), .sat (p2t_sat));
    lrd_mul u_mul_p1t (.aclk (aclk), .en (adv), .sh (SH_29),
                       .a (p1_ext), .b (ty_dly_reg[T_DLY-1]), .p (p1t_p), .sat (p1t_sat));

    sval_t                   dx1_s, dy1_s, dx_s, dy_s;
    logic signed [VAL_W-1:0] dx1_reg, dy1_reg, p2t_reg, p1t_reg, dx_reg, dy_reg;

    assign dx1_s = sat_add(xr_p, p1xy_p);
    assign dy1_s = sat_add(yr_p, p2xy_p);
    assign dx_s  = sat_add(dx1_reg, p2t_reg);
    assign dy_s  = sat_add(dy1_reg, p1t_reg);

    // pixel offsets
    logic signed [VAL_W-1:0] ox_p, oy_p;
    logic                    ox_sat, oy_sat;

    lrd_mul u_mul_ox (.aclk (aclk), .en (adv), .sh (SH_24), .a (fx_ext), .b (dx_reg),
                      .p (ox_p), .sat (ox_sat));
    lrd_mul u_mul_oy (.aclk (aclk), .en (adv), .sh (SH_24), .a (fy_ext), .b (dy_reg),
                      .p (oy_p), .sat (oy_sat));

    // saturation events join the item's sticky flag one stage after they are seen
    always_comb begin
        for (int t = 0; t <= S_OFF; t++) begin
            sat_ev[t] = 1'b0;
        end
        sat_ev[S_R2]   = sat_ev[S_R2] | xx_sat | yy_sat | xy_sat
                       | r2_s.sat | xx2_s.sat | yy2_s.sat;
        sat_ev[S_T]    = sat_ev[S_T] | tx_s.sat | ty_s.sat;
        sat_ev[S_R4+1] = sat_ev[S_R4+1] | r4_sat | k1r2_sat;
        sat_ev[S_K2+1] = sat_ev[S_K2+1] | k2r4_sat | rad_s.sat;
        sat_ev[S_D1]   = sat_ev[S_D1] | xr_sat | yr_sat | p1xy_sat | p2xy_sat
                       | p2t_sat | p1t_sat | dx1_s.sat | dy1_s.sat;
        sat_ev[S_D]    = sat_ev[S_D] | dx_s.sat | dy_s.sat;

        side_next[0].u   = s_data.pix_u;
        side_next[0].v   = s_data.pix_v;
        side_next[0].sat = 1'b0;
        for (int t = 1; t <= S_OFF; t++) begin
            side_next[t]     = side_reg[t-1];
            side_next[t].sat = side_reg[t-1].sat | sat_ev[t];
        end
    end

    // final add and clamp
    logic signed [VAL_W:0] sum_u, sum_v;
    logic                  clamp_u, clamp_v, bad;
    logic signed [VAL_W:0] cu, cv;
    out_item_t             out_reg, out_next;

    always_comb begin
        sum_u = $signed({{(VAL_W+1-PIX_W){1'b0}}, side_reg[S_OFF].u})
              + $signed({ox_p[VAL_W-1], ox_p});
        sum_v = $signed({{(VAL_W+1-PIX_W){1'b0}}, side_reg[S_OFF].v})
              + $signed({oy_p[VAL_W-1], oy_p});
        clamp_u = (sum_u > OUT_HI) || (sum_u < OUT_LO);
        clamp_v = (sum_v > OUT_HI) || (sum_v < OUT_LO);
        cu = (sum_u > OUT_HI) ? OUT_HI : ((sum_u < OUT_LO) ? OUT_LO : sum_u);
        cv = (sum_v > OUT_HI) ? OUT_HI : ((sum_v < OUT_LO) ? OUT_LO : sum_v);
        bad = (focal_x_reg == '0) || (focal_y_reg == '0);

        if (bad) begin
            out_next.dist_u    = '0;
            out_next.dist_v    = '0;
            out_next.bad_focal = 1'b1;
            out_next.clipped   = 1'b0;
        end else begin
            out_next.dist_u    = cu[OUT_W-1:0];
            out_next.dist_v    = cv[OUT_W-1:0];
            out_next.bad_focal = 1'b0;
            out_next.clipped   = side_reg[S_OFF].sat | ox_sat | oy_sat | clamp_u | clamp_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int t = 0; t <= S_OFF; t++) begin
                side_reg[t] <= side_next[t];
            end
            r2_reg  <= r2_s.val;
            xx2_reg <= xx2_s.val;
            yy2_reg <= yy2_s.val;
            tx_reg  <= tx_s.val;
            ty_reg  <= ty_s.val;
            rad_reg <= rad_s.val;

            k1_dly_reg[0] <= k1r2_p;
            for (int i = 1; i < K1_DLY; i++) begin
                k1_dly_reg[i] <= k1_dly_reg[i-1];
            end
            x_dly_reg[0] <= x_q;
            y_dly_reg[0] <= y_q;
            for (int i = 1; i < XY_DLY; i++) begin
                x_dly_reg[i] <= x_dly_reg[i-1];
                y_dly_reg[i] <= y_dly_reg[i-1];
            end
            xy_dly_reg[0] <= xy_p;
            for (int i = 1; i < PR_DLY; i++) begin
                xy_dly_reg[i] <= xy_dly_reg[i-1];
            end
            tx_dly_reg[0] <= tx_reg;
            ty_dly_reg[0] <= ty_reg;
            for (int i = 1; i < T_DLY; i++) begin
                tx_dly_reg[i] <= tx_dly_reg[i-1];
                ty_dly_reg[i] <= ty_dly_reg[i-1];
            end

            dx1_reg <= dx1_s.val;
            dy1_reg <= dy1_s.val;
            p2t_reg <= p2t_p;
            p1t_reg <= p1t_p;
            dx_reg  <= dx_s.val;
            dy_reg  <= dy_s.val;
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    a_bad_focal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_focal |->
            !m_data.clipped && m_data.dist_u == '0 && m_data.dist_v == '0)
        else $error("bad focal item carries nonzero payload");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

endmodule
